// ===== design/sars_pkg.sv =====
// Shared types and constants for the serial ADC read sequencer.
package sars_pkg;

	localparam int ADDRESS_BITS = 4;
	localparam int SAMPLE_BITS  = 10;
	localparam int DUMMY_CLOCKS = 6;
	localparam int CFG_WIDTH    = 8;
	localparam int CFG_INDEX_W  = 3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_SELECT_TICKS   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ADDR_SETUP     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_POLL_LIMIT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_READ_BIT_TICKS = 3'd5;

	// status codes
	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
	localparam logic [1:0] STATUS_BUSY    = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE         = 4'd0,
		PH_SEL1_HI      = 4'd1,
		PH_SEL1_LO      = 4'd2,
		PH_ADDR_SETUP   = 4'd3,
		PH_ADDR_CLK     = 4'd4,
		PH_POLL_CHECK   = 4'd5,
		PH_POLL_WAIT    = 4'd6,
		PH_SETTLE       = 4'd7,
		PH_SEL2_HI      = 4'd8,
		PH_SEL2_LO      = 4'd9,
		PH_READ_CLK     = 4'd10,
		PH_READ_GAP     = 4'd11,
		PH_DONE_OK      = 4'd12,
		PH_DONE_TIMEOUT = 4'd13,
		PH_DONE_BUSY    = 4'd14
	} phase_t;

	typedef struct packed {
		logic [7:0] select_ticks;
		logic [7:0] address_setup_ticks;
		logic [7:0] poll_interval_ticks;
		logic [3:0] poll_limit;
		logic [7:0] settle_ticks;
		logic [7:0] read_bit_ticks;
	} cfg_t;

	typedef struct packed {
		logic                   io_clock;
		logic                   address_line;
		logic                   chip_select;
		logic                   busy_res;
		logic                   done_res;
		logic [1:0]             status;
		logic [SAMPLE_BITS-1:0] sample;
	} result_t;

endpackage

// ===== design/sars_fsm.sv =====
// Phase machine: pin levels from the current phase, state advance per accepted tick.
module sars_fsm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                start_req,
	input  logic [sars_pkg::ADDRESS_BITS-1:0]   channel,
	input  logic                                eoc_level,
	input  logic                                dout_level,
	input  sars_pkg::cfg_t                      cfg,
	output sars_pkg::result_t                   res
);

	localparam int AB = sars_pkg::ADDRESS_BITS;
	localparam int SB = sars_pkg::SAMPLE_BITS;
	localparam logic [3:0] ADDR_CLOCKS  = 4'(AB);
	localparam logic [3:0] FRAME_CLOCKS = 4'(AB + sars_pkg::DUMMY_CLOCKS);
	localparam logic [3:0] READ_CLOCKS  = 4'(SB);

	sars_pkg::phase_t phase_q, phase_n;
	logic [3:0]    bit_q, bit_n;
	logic [7:0]    delay_q, delay_n;
	logic [3:0]    poll_q, poll_n;
	logic [AB-1:0] addr_q, addr_n;
	logic [SB-1:0] smp_q, smp_n;

	logic       expired;
	logic [7:0] delay_dec;
	logic [3:0] bit_inc;

	assign expired   = (delay_q <= 8'd1);
	assign delay_dec = expired ? 8'd0 : delay_q - 8'd1;
	assign bit_inc   = bit_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		delay_n = delay_q;
		poll_n  = poll_q;
		addr_n  = addr_q;
		smp_n   = smp_q;
		case (phase_q)
			sars_pkg::PH_IDLE: begin
				if (start_req) begin
					if (eoc_level) begin
						addr_n  = channel;
						bit_n   = 4'd0;
						poll_n  = 4'd0;
						smp_n   = '0;
						delay_n = cfg.select_ticks;
						phase_n = sars_pkg::PH_SEL1_HI;
					end else begin
						phase_n = sars_pkg::PH_DONE_BUSY;
					end
				end
			end
			sars_pkg::PH_SEL1_HI: begin
				delay_n = delay_dec;
				if (expired) begin
					delay_n = cfg.select_ticks;
					phase_n = sars_pkg::PH_SEL1_LO;
				end
			end
			sars_pkg::PH_SEL1_LO: begin
				delay_n = delay_dec;
				if (expired) begin
					delay_n = cfg.address_setup_ticks;
					phase_n = sars_pkg::PH_ADDR_SETUP;
				end
			end
			sars_pkg::PH_ADDR_SETUP: begin
				delay_n = delay_dec;
				if (expired)
					phase_n = sars_pkg::PH_ADDR_CLK;
			end
			sars_pkg::PH_ADDR_CLK: begin
				addr_n = {addr_q[AB-2:0], 1'b0};
				bit_n  = bit_inc;
				if (bit_inc >= FRAME_CLOCKS) begin
					poll_n  = 4'd0;
					phase_n = sars_pkg::PH_POLL_CHECK;
				end else begin
					// dummy clocks after the address use a one-tick setup
					delay_n = (bit_inc < ADDR_CLOCKS) ? cfg.address_setup_ticks : 8'd1;
					phase_n = sars_pkg::PH_ADDR_SETUP;
				end
			end
			sars_pkg::PH_POLL_CHECK: begin
				if (poll_q >= cfg.poll_limit) begin
					phase_n = sars_pkg::PH_DONE_TIMEOUT;
				end else if (eoc_level) begin
					delay_n = cfg.settle_ticks;
					phase_n = sars_pkg::PH_SETTLE;
				end else begin
					delay_n = cfg.poll_interval_ticks;
					phase_n = sars_pkg::PH_POLL_WAIT;
				end
			end
			sars_pkg::PH_POLL_WAIT: begin
				delay_n = delay_dec;
				if (expired) begin
					poll_n  = poll_q + 4'd1;
					phase_n = sars_pkg::PH_POLL_CHECK;
				end
			end
			sars_pkg::PH_SETTLE: begin
				delay_n = delay_dec;
				if (expired) begin
					delay_n = cfg.select_ticks;
					phase_n = sars_pkg::PH_SEL2_HI;
				end
			end
			sars_pkg::PH_SEL2_HI: begin
				delay_n = delay_dec;
				if (expired) begin
					delay_n = cfg.select_ticks;
					phase_n = sars_pkg::PH_SEL2_LO;
				end
			end
			sars_pkg::PH_SEL2_LO: begin
				delay_n = delay_dec;
				if (expired) begin
					bit_n   = 4'd0;
					phase_n = sars_pkg::PH_READ_CLK;
				end
			end
			sars_pkg::PH_READ_CLK: begin
				smp_n   = {smp_q[SB-2:0], dout_level};
				bit_n   = bit_inc;
				delay_n = cfg.read_bit_ticks;
				phase_n = sars_pkg::PH_READ_GAP;
			end
			sars_pkg::PH_READ_GAP: begin
				delay_n = delay_dec;
				if (expired)
					phase_n = (bit_q >= READ_CLOCKS) ? sars_pkg::PH_DONE_OK
						: sars_pkg::PH_READ_CLK;
			end
			default: begin
				phase_n = sars_pkg::PH_IDLE;
			end
		endcase
	end

	// pin levels and status follow the phase held at the start of the tick
	always_comb begin
		res              = '0;
		res.chip_select  = 1'b1;
		res.busy_res     = (phase_q >= sars_pkg::PH_SEL1_HI) && (phase_q <= sars_pkg::PH_READ_GAP);
		case (phase_q)
			sars_pkg::PH_SEL1_LO, sars_pkg::PH_SEL2_LO, sars_pkg::PH_READ_GAP: begin
				res.chip_select = 1'b0;
			end
			sars_pkg::PH_ADDR_SETUP: begin
				res.chip_select  = 1'b0;
				res.address_line = addr_q[AB-1];
			end
			sars_pkg::PH_ADDR_CLK: begin
				res.chip_select  = 1'b0;
				res.io_clock     = 1'b1;
				res.address_line = addr_q[AB-1];
			end
			sars_pkg::PH_READ_CLK: begin
				res.chip_select = 1'b0;
				res.io_clock    = 1'b1;
			end
			sars_pkg::PH_DONE_OK: begin
				res.done_res = 1'b1;
				res.status   = sars_pkg::STATUS_OK;
				res.sample   = smp_q;
			end
			sars_pkg::PH_DONE_TIMEOUT: begin
				res.done_res = 1'b1;
				res.status   = sars_pkg::STATUS_TIMEOUT;
			end
			sars_pkg::PH_DONE_BUSY: begin
				res.done_res = 1'b1;
				res.status   = sars_pkg::STATUS_BUSY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sars_pkg::PH_IDLE;
			bit_q   <= '0;
			delay_q <= '0;
			poll_q  <= '0;
			addr_q  <= '0;
			smp_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			delay_q <= delay_n;
			poll_q  <= poll_n;
			addr_q  <= addr_n;
			smp_q   <= smp_n;
		end
	end

endmodule

// ===== design/sars_skid.sv =====
// Result register with a skid entry so the input side never waits on out_stall directly.
module sars_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sars_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output sars_pkg::result_t out_data
);

	logic              main_v_q, skid_v_q;
	sars_pkg::result_t main_q, skid_q;
	logic              take;

	assign take      = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				// push only happens with the skid entry empty
				if (!main_v_q || take)
					main_v_q <= 1'b1;
				else
					skid_v_q <= 1'b1;
			end else if (take) begin
				main_v_q <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_v_q || take)
				main_q <= push_data;
			else
				skid_q <= push_data;
		end else if (take && skid_v_q) begin
			main_q <= skid_q;
		end
	end

endmodule

// ===== design/serial_adc_read_sequencer_unit.sv =====
// Top level of the serial ADC read sequencer: config registers, phase machine, result buffer.
//
//  channel   direction  handshake              beat payload
//  input     in         in_valid / in_stall    start_req, channel, eoc_level, dout_level
//  output    out        out_valid / out_stall  io_clock .. sample (one per input beat)
//  config    in         wr_en (no wait)        wr_index, wr_data
//
// One input beat per clock while in_stall is low; each beat is one tick of the phase
// machine and yields one result beat, registered in the result register or skid entry.
// in_stall rises only when both result entries are full, so up to two results are held.
// Reset puts the phase machine in idle and the config registers at their defaults.
module serial_adc_read_sequencer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_req,
	input  logic [sars_pkg::ADDRESS_BITS-1:0]   channel,
	input  logic                                eoc_level,
	input  logic                                dout_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                io_clock,
	output logic                                address_line,
	output logic                                chip_select,
	output logic                                busy_res,
	output logic                                done_res,
	output logic [1:0]                          status,
	output logic [sars_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                wr_en,
	input  logic [sars_pkg::CFG_INDEX_W-1:0]    wr_index,
	input  logic [sars_pkg::CFG_WIDTH-1:0]      wr_data
);

	sars_pkg::cfg_t    cfg_q;
	sars_pkg::result_t tick_res, out_res;
	logic              accept, skid_full;

	assign in_stall = skid_full;
	assign accept   = in_valid && !skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.select_ticks        <= 8'd1;
			cfg_q.address_setup_ticks <= 8'd2;
			cfg_q.poll_interval_ticks <= 8'd10;
			cfg_q.poll_limit          <= 4'd10;
			cfg_q.settle_ticks        <= 8'd10;
			cfg_q.read_bit_ticks      <= 8'd1;
		end else if (wr_en) begin
			case (wr_index)
				sars_pkg::REG_SELECT_TICKS:   cfg_q.select_ticks        <= wr_data;
				sars_pkg::REG_ADDR_SETUP:     cfg_q.address_setup_ticks <= wr_data;
				sars_pkg::REG_POLL_INTERVAL:  cfg_q.poll_interval_ticks <= wr_data;
				sars_pkg::REG_POLL_LIMIT:     cfg_q.poll_limit          <= wr_data[3:0];
				sars_pkg::REG_SETTLE_TICKS:   cfg_q.settle_ticks        <= wr_data;
				sars_pkg::REG_READ_BIT_TICKS: cfg_q.read_bit_ticks      <= wr_data;
				default: begin
				end
			endcase
		end
	end

	sars_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.start_req  (start_req),
		.channel    (channel),
		.eoc_level  (eoc_level),
		.dout_level (dout_level),
		.cfg        (cfg_q),
		.res        (tick_res)
	);

	sars_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (tick_res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign io_clock     = out_res.io_clock;
	assign address_line = out_res.address_line;
	assign chip_select  = out_res.chip_select;
	assign busy_res     = out_res.busy_res;
	assign done_res     = out_res.done_res;
	assign status       = out_res.status;
	assign sample       = out_res.sample;

endmodule
